// ===== rtl/core/pcle_pkg.sv =====
// Shared constants and control/status types of the pc/line table encoder.
package pcle_pkg;

    localparam int PC_QUANTUM_LOG2 = 1;
    localparam int PC_QUANTUM      = 1 << PC_QUANTUM_LOG2;
    localparam int MAX_PC_RUNS     = 59;
    localparam int RUN_MAX         = 127;
    localparam int MAX_UNITS       = MAX_PC_RUNS * RUN_MAX;
    localparam int UNITS_W         = $clog2(MAX_UNITS + 1);
    localparam int RUN_W           = $clog2(RUN_MAX + 1);

    localparam logic [7:0] PC_BYTE_BASE = 8'd128;
    localparam logic [7:0] PAD_BYTE     = 8'd129;
    localparam logic [7:0] ESC_BYTE     = 8'd0;
    localparam int         SHORT_RANGE  = 64;

    localparam int ESC_IDX_W    = 3;
    localparam logic [ESC_IDX_W-1:0] ESC_IDX_LAST = 3'd4;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // byte source select
    localparam logic [1:0] SEL_PC    = 2'd0;
    localparam logic [1:0] SEL_SHORT = 2'd1;
    localparam logic [1:0] SEL_ESC   = 2'd2;
    localparam logic [1:0] SEL_PAD   = 2'd3;

    typedef struct packed {
        logic       load;
        logic       eval;
        logic       emit;
        logic [1:0] sel;
    } pcle_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_end;
        logic rec_drop;
        logic odd;
        logic eval_skip_pc;
        logic run_final;
        logic short_delta;
        logic esc_last;
    } pcle_stat_t;

endpackage

// ===== rtl/core/pcle_dp.sv =====
// Datapath: pc/line history, deltas, run counter, escape bytes and output register.
module pcle_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pcle_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [pcle_pkg::IN_USER_W-1:0] s_tuser,
    input  logic                          cfg_we,
    input  logic [31:0]                   cfg_wdata,
    input  pcle_pkg::pcle_cmd_t           cmd,
    output pcle_pkg::pcle_stat_t          st,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pcle_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    import pcle_pkg::*;

    logic [31:0]          in_pc;
    logic [30:0]          in_line;

    logic [31:0]          prev_pc_reg, prev_pc_next;
    logic [30:0]          prev_line_reg, prev_line_next;
    logic                 odd_reg, odd_next;
    logic [31:0]          diff_reg, diff_next;
    logic [31:0]          delta_reg, delta_next;
    logic [UNITS_W-1:0]   units_reg, units_next;
    logic                 err_reg, err_next;
    logic                 short_reg, short_next;
    logic [7:0]           short_byte_reg, short_byte_next;
    logic [ESC_IDX_W-1:0] esc_idx_reg, esc_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_err_reg, out_err_next;

    logic [31:0]          diff_units;
    logic                 eval_err;
    logic [31:0]          mag;
    logic [RUN_W-1:0]     run;
    logic [7:0]           esc_byte;
    logic [7:0]           emit_byte;
    logic                 emit_last;
    logic                 emit_err;

    assign in_pc   = s_tdata[31:0];
    assign in_line = s_tdata[62:32];

    assign diff_units = diff_reg >> PC_QUANTUM_LOG2;
    assign eval_err   = diff_reg[31] || (diff_units > 32'(MAX_UNITS));
    assign mag        = 32'd0 - delta_reg;
    assign run        = (units_reg > UNITS_W'(RUN_MAX)) ? RUN_W'(RUN_MAX)
                                                        : units_reg[RUN_W-1:0];

    always_comb
    begin
        unique case (esc_idx_reg)
            3'd0:    esc_byte = ESC_BYTE;
            3'd1:    esc_byte = delta_reg[31:24];
            3'd2:    esc_byte = delta_reg[23:16];
            3'd3:    esc_byte = delta_reg[15:8];
            3'd4:    esc_byte = delta_reg[7:0];
            default: esc_byte = ESC_BYTE;
        endcase
    end

    always_comb
    begin
        unique case (cmd.sel)
            SEL_PC:
            begin
                emit_byte = PC_BYTE_BASE + {1'b0, run};
                emit_last = 1'b0;
                emit_err  = 1'b0;
            end
            SEL_SHORT:
            begin
                emit_byte = short_byte_reg;
                emit_last = 1'b1;
                emit_err  = err_reg;
            end
            SEL_ESC:
            begin
                emit_byte = esc_byte;
                emit_last = (esc_idx_reg == ESC_IDX_LAST);
                emit_err  = err_reg;
            end
            default:
            begin
                emit_byte = PAD_BYTE;
                emit_last = 1'b1;
                emit_err  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        prev_pc_next    = prev_pc_reg;
        prev_line_next  = prev_line_reg;
        odd_next        = odd_reg;
        diff_next       = diff_reg;
        delta_next      = delta_reg;
        units_next      = units_reg;
        err_next        = err_reg;
        short_next      = short_reg;
        short_byte_next = short_byte_reg;
        esc_idx_next    = esc_idx_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;

        if (cfg_we)
        begin
            prev_pc_next = cfg_wdata;
        end

        if (cmd.load)
        begin
            diff_next      = in_pc - prev_pc_reg;
            delta_next     = {1'b0, in_line} - {1'b0, prev_line_reg};
            prev_pc_next   = in_pc + 32'(PC_QUANTUM);
            prev_line_next = in_line;
        end

        if (cmd.eval)
        begin
            units_next   = diff_units[UNITS_W-1:0];
            err_next     = eval_err;
            esc_idx_next = '0;
            if (delta_reg[31])
            begin
                short_next      = (mag <= 32'(SHORT_RANGE));
                short_byte_next = 8'(SHORT_RANGE) + mag[7:0];
            end
            else
            begin
                short_next      = (delta_reg <= 32'(SHORT_RANGE));
                short_byte_next = delta_reg[7:0];
            end
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
            out_err_next   = emit_err;
            odd_next       = ~odd_reg;
            if (cmd.sel == SEL_PC)
            begin
                units_next = units_reg - UNITS_W'(run);
            end
            if (cmd.sel == SEL_ESC)
            begin
                esc_idx_next = esc_idx_reg + ESC_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pc_reg   <= '0;
            prev_line_reg <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_pc_reg   <= prev_pc_next;
            prev_line_reg <= prev_line_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg       <= diff_next;
        delta_reg      <= delta_next;
        units_reg      <= units_next;
        err_reg        <= err_next;
        short_reg      <= short_next;
        short_byte_reg <= short_byte_next;
        esc_idx_reg    <= esc_idx_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_err_reg    <= out_err_next;
    end

    assign st.out_free     = !out_valid_reg || m_tready;
    assign st.is_end       = s_tuser[0];
    assign st.rec_drop     = s_tuser[1] || (in_line == prev_line_reg);
    assign st.odd          = odd_reg;
    assign st.eval_skip_pc = eval_err || (diff_units == 32'd0);
    assign st.run_final    = (units_reg <= UNITS_W'(RUN_MAX));
    assign st.short_delta  = short_reg;
    assign st.esc_last     = (esc_idx_reg == ESC_IDX_LAST);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

// ===== rtl/core/pcle_ctrl.sv =====
// Controller: sequences record intake, evaluation and byte emission.
module pcle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pcle_pkg::pcle_stat_t st,
    output pcle_pkg::pcle_cmd_t  cmd
);
    import pcle_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_PC   = 3'd2;
    localparam logic [2:0] S_LINE = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (st.is_end)
                    begin
                        if (st.odd)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (!st.rec_drop)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = st.eval_skip_pc ? S_LINE : S_PC;
            end
            S_PC:
            begin
                cmd.sel = SEL_PC;
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.run_final)
                    begin
                        state_next = S_LINE;
                    end
                end
            end
            S_LINE:
            begin
                cmd.sel = st.short_delta ? SEL_SHORT : SEL_ESC;
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.short_delta || st.esc_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PAD:
            begin
                cmd.sel = SEL_PAD;
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/pc_line_table_encoder.sv =====
// Top level of the pc/line table encoder: controller, datapath and checks.
// A record is loaded on its input transfer, evaluated, then its bytes leave through the
// output register. One record at a time: input is taken only in idle; an emitting record
// gives ceil(units/127) pc bytes and 1 or 5 line bytes, one byte per cycle while the
// receiver is ready; dropped records emit none. End record: pad byte only on odd count.
// Reset (rst_n low, async): previous pc, previous line and byte parity clear to zero.
module pc_line_table_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcle_pkg::IN_DATA_W-1:0]  s_tdata,   // pc[31:0], line[62:32], zero[63]
    input  logic [pcle_pkg::IN_USER_W-1:0]  s_tuser,   // action[0], skip[1]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pcle_pkg::OUT_DATA_W-1:0] m_tdata,   // table_byte[7:0]
    output logic                            m_tlast,
    output logic                            m_tuser,   // error[0]
    input  logic                            cfg_we,
    input  logic [31:0]                     cfg_wdata
);
    import pcle_pkg::*;

    pcle_cmd_t  cmd;
    pcle_stat_t st;

    pcle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pcle_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // pc run bytes never end a record and never flag an error
    a_pc_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.sel == SEL_PC)) |=> (!m_tlast && !m_tuser))
        else $error("pc run byte marked last or error");

    // pad byte is a clean final byte
    a_pad_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.sel == SEL_PAD)) |=> ((m_tdata == PAD_BYTE) && m_tlast && !m_tuser))
        else $error("pad byte wrong value or flags");

    // parity flips on every emitted byte
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (st.odd != $past(st.odd)))
        else $error("byte parity not updated on emit");

    // end record with even count emits nothing and frees the input at once
    a_even_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] && !st.odd) |=> s_tready)
        else $error("even end record did not complete immediately");

endmodule

// ===== tb/tb_pc_line_table_encoder.sv =====
// Self-checking testbench for the pc/line table encoder with scoreboard and random stimulus.
`timescale 1ns / 1ps
module tb_pc_line_table_encoder;
    import pcle_pkg::*;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_END = 1'b1;
    localparam logic [30:0] LINE_MAX = 31'h7FFF_FFFF;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL = 400;
    localparam int GAP_PCT = 27;
    localparam int RANDOM_ITEMS = 100;
    localparam int PC_SPAN = 2 * MAX_UNITS;

    typedef struct {
        logic [7:0] value;
        logic last;
        logic err;
    } table_entry_t;

    class pc_table_scoreboard;
        logic [31:0] base_pc;
        logic [31:0] prev_pc;
        logic [31:0] prev_line;
        bit odd;
        table_entry_t expected_bytes[$];
        int failures;
        int bytes_seen;
        int records;
        int dropped;
        int end_records;
        int bad_advances;

        function new();
            base_pc = '0;
            prev_pc = '0;
            prev_line = '0;
            odd = 1'b0;
            failures = 0;
            bytes_seen = 0;
            records = 0;
            dropped = 0;
            end_records = 0;
            bad_advances = 0;
        endfunction

        function void set_base(logic [31:0] value);
            base_pc = value;
            prev_pc = value;
        endfunction

        function void emit(logic [7:0] value, logic err);
            table_entry_t e;
            e.value = value;
            e.last = 1'b0;
            e.err = err;
            expected_bytes.push_back(e);
            odd = !odd;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void note_transfer(logic action, logic [31:0] pc, logic [30:0] line,
                                    logic skip);
            logic [31:0] diff;
            logic [31:0] units;
            logic [31:0] run;
            logic [31:0] delta;
            logic [31:0] mag;
            logic bad;
            int first;
            first = expected_bytes.size();
            if (action == ACT_END)
            begin
                end_records++;
                if (odd)
                    emit(PAD_BYTE, 1'b0);
            end
            else if (skip || {1'b0, line} == prev_line)
            begin
                dropped++;
            end
            else
            begin
                records++;
                diff = pc - prev_pc;
                bad = diff[31];
                units = '0;
                if (!bad)
                begin
                    units = diff / 32'(PC_QUANTUM);
                    if (units > 32'(MAX_UNITS))
                        bad = 1'b1;
                end
                if (bad)
                    bad_advances++;
                else
                    while (units != 0)
                    begin
                        run = (units > 32'(RUN_MAX)) ? 32'(RUN_MAX) : units;
                        emit(PC_BYTE_BASE + run[7:0], 1'b0);
                        units = units - run;
                    end
                delta = {1'b0, line} - prev_line;
                prev_line = {1'b0, line};
                prev_pc = pc + 32'(PC_QUANTUM);
                mag = delta[31] ? -delta : delta;
                if (mag > 32'(SHORT_RANGE))
                begin
                    emit(ESC_BYTE, bad);
                    emit(delta[31:24], bad);
                    emit(delta[23:16], bad);
                    emit(delta[15:8], bad);
                    emit(delta[7:0], bad);
                end
                else if (delta[31])
                    emit(8'(SHORT_RANGE) + mag[7:0], bad);
                else
                    emit(delta[7:0], bad);
            end
            if (expected_bytes.size() > first)
                expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        endfunction

        function void check_byte(logic [7:0] value, logic last, logic err);
            table_entry_t e;
            bytes_seen++;
            if (expected_bytes.size() == 0)
            begin
                failures++;
                $error("table_byte: no transfer expected, actual %0d", value);
                return;
            end
            e = expected_bytes.pop_front();
            if (value !== e.value)
            begin
                failures++;
                $error("table_byte: expected %0d, actual %0d", e.value, value);
            end
            if (last !== e.last)
            begin
                failures++;
                $error("last: expected %0b, actual %0b", e.last, last);
            end
            if (err !== e.err)
            begin
                failures++;
                $error("error: expected %0b, actual %0b", e.err, err);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [IN_USER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    logic no_gaps;
    int stall_requests;
    int stall_served = 0;
    int stall_left = 0;

    pc_table_scoreboard sb = new();

    pc_line_table_encoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random backpressure, long hold-off on request
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_served != stall_requests)
        begin
            stall_served <= stall_served + 1;
            stall_left <= LONG_STALL;
            m_tready <= 1'b0;
        end
        else if (no_gaps)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= GAP_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tlast, m_tuser);
    end

    task automatic send_item(logic action, logic [31:0] pc, logic [30:0] line, logic skip);
        if (!no_gaps)
            while ($urandom_range(0, 99) < GAP_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, line, pc};
        s_tuser <= {skip, action};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_transfer(action, pc, line, skip);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(logic [31:0] value);
        quiesce();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_base(value);
    endtask

    task automatic send_directed();
        send_item(ACT_RECORD, 32'd0, 31'd1, 1'b0);
        send_item(ACT_END, $urandom(), 31'($urandom()), 1'b1);
        send_item(ACT_END, $urandom(), 31'($urandom()), 1'b0);
        send_item(ACT_RECORD, sb.prev_pc + 2 * RUN_MAX, 31'd65, 1'b0);
        send_item(ACT_RECORD, sb.prev_pc + 2 * (RUN_MAX + 1), 31'd1, 1'b0);
        send_item(ACT_RECORD, sb.prev_pc + PC_SPAN, 31'd0, 1'b0);
        // advance one unit beyond the encodable runs
        send_item(ACT_RECORD, sb.prev_pc + PC_SPAN + 2, 31'd66, 1'b0);
        send_item(ACT_RECORD, sb.prev_pc + 3, 31'd1, 1'b0);
        send_item(ACT_RECORD, 32'd0, 31'd5, 1'b1);
        send_item(ACT_RECORD, $urandom(), 31'd1, 1'b0);
        send_item(ACT_RECORD, 32'd0, LINE_MAX, 1'b0);
        send_item(ACT_RECORD, 32'd2, 31'd0, 1'b0);
        send_item(ACT_RECORD, 32'hFFFF_FFFE, 31'd64, 1'b0);
        send_item(ACT_RECORD, 32'd0, 31'd0, 1'b0);
        send_item(ACT_RECORD, sb.prev_pc + 1, 31'd1, 1'b0);
        send_item(ACT_RECORD, sb.prev_pc + 32'h8000_0000, 31'd2, 1'b0);
        send_item(ACT_RECORD, sb.prev_pc + 32'h7FFF_FFFE, 31'd3, 1'b0);
        send_item(ACT_RECORD, sb.prev_pc - 2, 31'd70, 1'b0);
        send_item(ACT_RECORD, sb.prev_pc, 31'd5, 1'b0);
        send_item(ACT_END, 32'hFFFF_FFFF, LINE_MAX, 1'b1);
        send_item(ACT_END, 32'd0, 31'd0, 1'b0);
    endtask

    task automatic send_random(int count, int phase);
        int kind;
        int p;
        int q;
        int d;
        logic [31:0] pc;
        logic [30:0] line;
        for (int i = 0; i < count; i++)
        begin
            if (phase == 1 && i == 20)
                no_gaps <= 1'b1;
            if (phase == 1 && i == 80)
                no_gaps <= 1'b0;
            if (phase == 2 && i == 30)
                stall_requests <= stall_requests + 1;
            if (phase == 3 && i == 50)
                quiesce();
            kind = $urandom_range(0, 99);
            p = $urandom_range(0, 99);
            q = $urandom_range(0, 99);
            if (p < 60)
                pc = sb.prev_pc + $urandom_range(0, 40);
            else if (p < 75)
                pc = sb.prev_pc + $urandom_range(41, 1500);
            else if (p < 80)
                pc = sb.prev_pc + $urandom_range(PC_SPAN - 4, PC_SPAN + 6);
            else if (p < 88)
                pc = sb.prev_pc - $urandom_range(1, 200);
            else
                pc = $urandom();
            if (q < 55)
                d = $urandom_range(1, 64);
            else if (q < 75)
                d = $urandom_range(65, 5000);
            else
                d = 0;
            if (d != 0)
                line = $urandom_range(0, 1) ? sb.prev_line[30:0] - 31'(d)
                                            : sb.prev_line[30:0] + 31'(d);
            else if (q < 92)
                line = 31'($urandom());
            else
                line = $urandom_range(0, 1) ? LINE_MAX : 31'd0;
            if (kind < 8)
                send_item(ACT_END, $urandom(), 31'($urandom()), 1'($urandom()));
            else if (kind < 12)
                send_item(ACT_RECORD, pc, line, 1'b1);
            else if (kind < 16)
                send_item(ACT_RECORD, pc, sb.prev_line[30:0], 1'b0);
            else
                send_item(ACT_RECORD, pc, line, 1'b0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        no_gaps = 1'b0;
        stall_requests = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base(32'd0);
        send_directed();
        send_random(RANDOM_ITEMS, 0);
        write_base(32'hFFFF_FFF0);
        send_random(RANDOM_ITEMS, 1);
        write_base($urandom());
        send_random(RANDOM_ITEMS, 2);
        write_base(32'hFFFF_FFFF);
        send_random(RANDOM_ITEMS, 3);
        quiesce();

        $display("Covered %0d line records, %0d dropped, %0d end records, %0d bad pc advances",
                 sb.records, sb.dropped, sb.end_records, sb.bad_advances);
        $display("%0d table bytes checked over four base_pc settings", sb.bytes_seen);
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== pc_line_table_encoder.f =====
rtl/core/pcle_pkg.sv
rtl/core/pcle_dp.sv
rtl/core/pcle_ctrl.sv
rtl/core/pc_line_table_encoder.sv
tb/tb_pc_line_table_encoder.sv
